// ----- src/seeded_cone_jet_finder_top_macros.svh -----
// Assertion macros shared by the seeded cone jet finder RTL.
`ifndef SEEDED_CONE_JET_FINDER_TOP_MACROS_SVH
`define SEEDED_CONE_JET_FINDER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SCJF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SCJF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/scjf_pkg.sv -----
// Types and constants of the seeded cone jet finder.
package scjf_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    FUNC_SEED = 2'd0,
    FUNC_PART = 2'd1,
    FUNC_RUN  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  // Configuration register indexes
  localparam logic [1:0] REG_CONE   = 2'd0;
  localparam logic [1:0] REG_PTMIN  = 2'd1;
  localparam logic [1:0] REG_UNIQUE = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] CONE_RST  = 16'd2867;
  localparam logic [23:0] PTMIN_RST = 24'd5000;

  // pi and 2*pi in units of 1/4096
  localparam logic signed [16:0] PI_FX     = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_FX = 17'sd25736;

  // Saturation limits
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic [30:0]        E31_MAX = 31'h7fff_ffff;
  localparam logic [8:0]         CNT_MAX = 9'd511;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STREAM,
    ST_DRAIN,
    ST_SEL,
    ST_MUL,
    ST_CMP,
    ST_FIN
  } state_e;

  // One stored particle
  typedef struct packed {
    logic signed [15:0] eta;
    logic signed [14:0] phi;
    logic signed [23:0] mom_x;
    logic signed [23:0] mom_y;
    logic signed [23:0] mom_z;
    logic [22:0]        energy;
  } part_t;

  // Particle word moving along the cell chain
  typedef struct packed {
    logic  valid;
    logic  last;
    logic  taken;
    part_t part;
  } flow_t;

  // Per-seed accumulators
  typedef struct packed {
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic signed [31:0] sum_z;
    logic [30:0]        sum_e;
    logic [8:0]         count;
  } jet_t;

endpackage

// ----- src/scjf_if.sv -----
// Valid/ready channel interfaces for input and result words.
interface scjf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] eta;
  logic signed [14:0] phi;
  logic signed [23:0] mom_x;
  logic signed [23:0] mom_y;
  logic signed [23:0] mom_z;
  logic [22:0]        energy;

  modport source (output valid, func, eta, phi, mom_x, mom_y, mom_z, energy, input ready);
  modport sink   (input valid, func, eta, phi, mom_x, mom_y, mom_z, energy, output ready);
endinterface

interface scjf_out_if;
  logic               valid;
  logic               ready;
  logic               jet_valid;
  logic [4:0]         seed_index;
  logic signed [31:0] sum_x;
  logic signed [31:0] sum_y;
  logic signed [31:0] sum_z;
  logic [30:0]        sum_energy;
  logic [8:0]         member_count;
  logic               last_jet;

  modport source (output valid, jet_valid, seed_index, sum_x, sum_y, sum_z, sum_energy,
                  member_count, last_jet, input ready);
  modport sink   (input valid, jet_valid, seed_index, sum_x, sum_y, sum_z, sum_energy,
                  member_count, last_jet, output ready);
endinterface

// ----- src/scjf_cell.sv -----
// One seed cell: cone test and saturating four-momentum accumulation.
module scjf_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  seed_we_i,
  input  logic signed [15:0]    seed_eta_i,
  input  logic signed [14:0]    seed_phi_i,
  input  logic [31:0]           r2_i,
  input  logic                  unique_i,
  input  scjf_pkg::flow_t       flow_i,
  output scjf_pkg::flow_t       flow_o,
  output scjf_pkg::jet_t        jet_o
);

  logic signed [15:0] seed_eta_q;
  logic signed [14:0] seed_phi_q;

  logic signed [15:0] dphi_raw;
  logic [15:0]        dphi_abs;
  logic signed [16:0] dphi_ext;
  logic signed [16:0] dphi_fold;
  logic signed [16:0] deta;
  logic signed [33:0] dphi_sq;
  logic signed [33:0] deta_sq;
  logic [34:0]        dist2_d;
  logic [34:0]        dist2_q;

  scjf_pkg::flow_t fa_q;
  scjf_pkg::flow_t fb_d;
  scjf_pkg::flow_t fb_q;
  scjf_pkg::jet_t  jet_d;
  scjf_pkg::jet_t  jet_q;

  logic               hit;
  logic signed [32:0] sx;
  logic signed [32:0] sy;
  logic signed [32:0] sz;
  logic [31:0]        se;

  // Seed load
  always_ff @(posedge clk_i) begin
    if (seed_we_i) begin
      seed_eta_q <= seed_eta_i;
      seed_phi_q <= seed_phi_i;
    end
  end

  // Stage A: squared eta-phi distance, phi folded across pi
  always_comb begin
    dphi_raw  = 16'(seed_phi_q) - 16'(flow_i.part.phi);
    dphi_abs  = dphi_raw[15] ? 16'(-dphi_raw) : dphi_raw;
    dphi_ext  = signed'({1'b0, dphi_abs});
    dphi_fold = (dphi_ext > scjf_pkg::PI_FX) ? scjf_pkg::TWO_PI_FX - dphi_ext : dphi_ext;
    deta      = 17'(seed_eta_q) - 17'(flow_i.part.eta);
    dphi_sq   = dphi_fold * dphi_fold;
    deta_sq   = deta * deta;
    dist2_d   = 35'($unsigned(dphi_sq)) + 35'($unsigned(deta_sq));
  end

  // Stage B: cone test, eligibility and saturating sums
  always_comb begin
    hit = fa_q.valid && !(unique_i && fa_q.taken) && (dist2_q <= 35'(r2_i));
    sx  = 33'(jet_q.sum_x) + 33'(fa_q.part.mom_x);
    sy  = 33'(jet_q.sum_y) + 33'(fa_q.part.mom_y);
    sz  = 33'(jet_q.sum_z) + 33'(fa_q.part.mom_z);
    se  = {1'b0, jet_q.sum_e} + 32'(fa_q.part.energy);
    jet_d = jet_q;
    fb_d  = fa_q;
    if (clear_i) begin
      jet_d = '0;
    end else if (hit) begin
      jet_d.sum_x = (sx[32] != sx[31]) ? (sx[32] ? scjf_pkg::S32_MIN : scjf_pkg::S32_MAX)
                                       : sx[31:0];
      jet_d.sum_y = (sy[32] != sy[31]) ? (sy[32] ? scjf_pkg::S32_MIN : scjf_pkg::S32_MAX)
                                       : sy[31:0];
      jet_d.sum_z = (sz[32] != sz[31]) ? (sz[32] ? scjf_pkg::S32_MIN : scjf_pkg::S32_MAX)
                                       : sz[31:0];
      jet_d.sum_e = se[31] ? scjf_pkg::E31_MAX : se[30:0];
      if (jet_q.count != scjf_pkg::CNT_MAX) begin
        jet_d.count = jet_q.count + 9'd1;
      end
      fb_d.taken = 1'b1;
    end
  end

  // Flow registers between the two stages and toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_q <= '0;
      fb_q <= '0;
    end else begin
      fa_q <= flow_i;
      fb_q <= fb_d;
    end
  end

  // Distance and accumulators
  always_ff @(posedge clk_i) begin
    dist2_q <= dist2_d;
    jet_q   <= jet_d;
  end

  assign flow_o = fb_q;
  assign jet_o  = jet_q;

endmodule

// ----- src/scjf_chain.sv -----
// Row of seed cells; each particle word passes the flow registers fa_q and fb_q of every cell.
module scjf_chain #(
  parameter int MAX_SEEDS = 32,
  parameter int SCW       = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               seed_we_i,
  input  logic [SCW-1:0]     seed_cnt_i,
  input  logic signed [15:0] seed_eta_i,
  input  logic signed [14:0] seed_phi_i,
  input  logic [31:0]        r2_i,
  input  logic               unique_i,
  input  scjf_pkg::flow_t    flow_i,
  output scjf_pkg::flow_t    flow_o,
  output scjf_pkg::jet_t     jet_o [MAX_SEEDS]
);

  scjf_pkg::flow_t link [MAX_SEEDS+1];

  assign link[0] = flow_i;

  for (genvar k = 0; k < MAX_SEEDS; k++) begin : g_cell
    scjf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (clear_i),
      .seed_we_i  (seed_we_i && (seed_cnt_i == SCW'(k))),
      .seed_eta_i (seed_eta_i),
      .seed_phi_i (seed_phi_i),
      .r2_i       (r2_i),
      .unique_i   (unique_i),
      .flow_i     (link[k]),
      .flow_o     (link[k+1]),
      .jet_o      (jet_o[k])
    );
  end

  assign flow_o = link[MAX_SEEDS];

endmodule

// ----- src/seeded_cone_jet_finder_top.sv -----
// Seeded cone jet finder: load words store seeds and particles. A run streams every
// loaded particle from the particle memory through a row of MAX_SEEDS seed
// cells, one particle per cycle, through the flow registers fa_q and fb_q of
// each cell (no streaming when no particle is loaded). It then checks the seeds
// one at a time through a shared squaring unit in the steps SEL, MUL and CMP,
// and sends the final result word in FIN. The next word is accepted once the
// final result word is registered; with no seeds the run goes straight to FIN.
// Result words may stall at the output register and stretch the selection
// phase.
`include "seeded_cone_jet_finder_top_macros.svh"

module seeded_cone_jet_finder_top #(
  parameter int MAX_SEEDS     = 32,
  parameter int MAX_PARTICLES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  scjf_in_if.sink     in_i,
  scjf_out_if.source  out_o
);

  localparam int SCW = $clog2(MAX_SEEDS + 1);
  localparam int SIW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int PCW = $clog2(MAX_PARTICLES + 1);
  localparam int PIW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  // Configuration
  logic [15:0] cone_q;
  logic [23:0] ptmin_q;
  logic        uniq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cone_q  <= scjf_pkg::CONE_RST;
      ptmin_q <= scjf_pkg::PTMIN_RST;
      uniq_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scjf_pkg::REG_CONE:   cone_q  <= cfg_data_i[15:0];
        scjf_pkg::REG_PTMIN:  ptmin_q <= cfg_data_i;
        scjf_pkg::REG_UNIQUE: uniq_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  scjf_pkg::state_e state_q, state_d;
  scjf_pkg::func_e  func;
  logic             acc;
  logic             run_go;
  logic             seed_we;
  logic             part_we;

  logic [SCW-1:0] seed_cnt_q;
  logic [PCW-1:0] part_cnt_q;
  logic [PCW-1:0] iss_q;
  logic [SCW-1:0] idx_q;
  logic [SCW-1:0] idx_nxt;
  logic [6:0]     idx_ext;
  logic           iss_last;

  logic [31:0] r2_q;
  logic [47:0] pt2min_q;

  scjf_pkg::part_t part_in;
  scjf_pkg::part_t mem [MAX_PARTICLES];
  scjf_pkg::part_t rd_q;
  logic            feed_valid_q;
  logic            feed_last_q;
  scjf_pkg::flow_t feed;
  scjf_pkg::flow_t chain_end;
  scjf_pkg::jet_t  cell_jet [MAX_SEEDS];

  scjf_pkg::jet_t  cur_q;
  logic [4:0]      cur_idx_q;
  logic [62:0]     sx2_q;
  logic [62:0]     sy2_q;
  logic [63:0]     pt2;
  logic            pass;

  logic            pend_q;
  scjf_pkg::jet_t  pend_jet_q;
  logic [4:0]      pend_idx_q;

  logic            out_free;
  logic            push_pend;
  logic            take_cur;
  logic            push_final;
  logic            adv;

  logic            ov_q;
  scjf_pkg::jet_t  o_jet_q;
  logic [4:0]      o_idx_q;
  logic            o_jv_q;
  logic            o_last_q;

  // Input decode
  assign func    = scjf_pkg::func_e'(in_i.func);
  assign in_i.ready = (state_q == scjf_pkg::ST_IDLE);
  assign acc     = in_i.valid && in_i.ready;
  assign run_go  = acc && (func == scjf_pkg::FUNC_RUN);
  assign seed_we = acc && (func == scjf_pkg::FUNC_SEED) && (seed_cnt_q < SCW'(MAX_SEEDS));
  assign part_we = acc && (func == scjf_pkg::FUNC_PART) && (part_cnt_q < PCW'(MAX_PARTICLES));

  assign part_in = '{eta: in_i.eta, phi: in_i.phi, mom_x: in_i.mom_x, mom_y: in_i.mom_y,
                     mom_z: in_i.mom_z, energy: in_i.energy};

  assign iss_last = ((iss_q + PCW'(1)) == part_cnt_q);
  assign idx_nxt  = idx_q + SCW'(1);
  assign idx_ext  = 7'(idx_q);
  assign out_free = !ov_q || out_o.ready;

  // Jet test on the squared sums; both squares at -2^31 add up to 2^63
  assign pt2  = 64'(sx2_q) + 64'(sy2_q);
  assign pass = (pt2 >= 64'(pt2min_q));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scjf_pkg::ST_IDLE: begin
        if (run_go) begin
          if (seed_cnt_q == '0) begin
            state_d = scjf_pkg::ST_FIN;
          end else if (part_cnt_q == '0) begin
            state_d = scjf_pkg::ST_SEL;
          end else begin
            state_d = scjf_pkg::ST_STREAM;
          end
        end
      end
      scjf_pkg::ST_STREAM: begin
        if (iss_last) state_d = scjf_pkg::ST_DRAIN;
      end
      scjf_pkg::ST_DRAIN: begin
        if (chain_end.valid && chain_end.last) state_d = scjf_pkg::ST_SEL;
      end
      scjf_pkg::ST_SEL: state_d = scjf_pkg::ST_MUL;
      scjf_pkg::ST_MUL: state_d = scjf_pkg::ST_CMP;
      scjf_pkg::ST_CMP: begin
        if (!pass || !pend_q || out_free) begin
          state_d = (idx_nxt == seed_cnt_q) ? scjf_pkg::ST_FIN : scjf_pkg::ST_SEL;
        end
      end
      scjf_pkg::ST_FIN: begin
        if (out_free) state_d = scjf_pkg::ST_IDLE;
      end
      default: state_d = scjf_pkg::ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    push_pend  = 1'b0;
    take_cur   = 1'b0;
    push_final = 1'b0;
    adv        = 1'b0;
    unique case (state_q)
      scjf_pkg::ST_CMP: begin
        if (!pass) begin
          adv = 1'b1;
        end else if (!pend_q || out_free) begin
          adv       = 1'b1;
          take_cur  = 1'b1;
          push_pend = pend_q;
        end
      end
      scjf_pkg::ST_FIN: push_final = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= scjf_pkg::ST_IDLE;
      seed_cnt_q   <= '0;
      part_cnt_q   <= '0;
      iss_q        <= '0;
      idx_q        <= '0;
      feed_valid_q <= 1'b0;
      pend_q       <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      feed_valid_q <= (state_q == scjf_pkg::ST_STREAM);
      if (seed_we) seed_cnt_q <= seed_cnt_q + SCW'(1);
      if (part_we) part_cnt_q <= part_cnt_q + PCW'(1);
      if (run_go) begin
        iss_q <= '0;
        idx_q <= '0;
      end
      if (state_q == scjf_pkg::ST_STREAM) iss_q <= iss_q + PCW'(1);
      if (adv) idx_q <= idx_nxt;
      if (take_cur) pend_q <= 1'b1;
      if (push_final) begin
        pend_q     <= 1'b0;
        seed_cnt_q <= '0;
        part_cnt_q <= '0;
      end
      if (push_pend || push_final) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Particle memory and stream feed
  always_ff @(posedge clk_i) begin
    if (part_we) mem[part_cnt_q[PIW-1:0]] <= part_in;
    rd_q        <= mem[iss_q[PIW-1:0]];
    feed_last_q <= iss_last;
  end

  assign feed = '{valid: feed_valid_q, last: feed_last_q, taken: 1'b0, part: rd_q};

  scjf_chain #(
    .MAX_SEEDS (MAX_SEEDS),
    .SCW       (SCW)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (run_go),
    .seed_we_i  (seed_we),
    .seed_cnt_i (seed_cnt_q),
    .seed_eta_i (in_i.eta),
    .seed_phi_i (in_i.phi),
    .r2_i       (r2_q),
    .unique_i   (uniq_q),
    .flow_i     (feed),
    .flow_o     (chain_end),
    .jet_o      (cell_jet)
  );

  // Thresholds, selection, squaring and result payload
  always_ff @(posedge clk_i) begin
    if (run_go) begin
      r2_q     <= 32'(cone_q) * 32'(cone_q);
      pt2min_q <= 48'(ptmin_q) * 48'(ptmin_q);
    end
    if (state_q == scjf_pkg::ST_SEL) begin
      cur_q     <= cell_jet[idx_q[SIW-1:0]];
      cur_idx_q <= idx_ext[4:0];
    end
    if (state_q == scjf_pkg::ST_MUL) begin
      sx2_q <= 63'($unsigned(64'(cur_q.sum_x) * 64'(cur_q.sum_x)));
      sy2_q <= 63'($unsigned(64'(cur_q.sum_y) * 64'(cur_q.sum_y)));
    end
    if (take_cur) begin
      pend_jet_q <= cur_q;
      pend_idx_q <= cur_idx_q;
    end
    if (push_pend) begin
      o_jet_q  <= pend_jet_q;
      o_idx_q  <= pend_idx_q;
      o_jv_q   <= 1'b1;
      o_last_q <= 1'b0;
    end else if (push_final) begin
      o_jet_q  <= pend_q ? pend_jet_q : '0;
      o_idx_q  <= pend_q ? pend_idx_q : 5'd0;
      o_jv_q   <= pend_q;
      o_last_q <= 1'b1;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.jet_valid    = o_jv_q;
  assign out_o.seed_index   = o_idx_q;
  assign out_o.sum_x        = o_jet_q.sum_x;
  assign out_o.sum_y        = o_jet_q.sum_y;
  assign out_o.sum_z        = o_jet_q.sum_z;
  assign out_o.sum_energy   = o_jet_q.sum_e;
  assign out_o.member_count = o_jet_q.count;
  assign out_o.last_jet     = o_last_q;

  // Checks
  `SCJF_ASSERT_IMP(a_seed_cnt_bound, 1'b1, seed_cnt_q <= SCW'(MAX_SEEDS), "seed count overflow")
  `SCJF_ASSERT_NXT(a_run_clears, push_final, (seed_cnt_q == '0) && (part_cnt_q == '0), "counts not cleared after run")
  `SCJF_ASSERT_IMP(a_pend_phase, pend_q, (state_q == scjf_pkg::ST_SEL) || (state_q == scjf_pkg::ST_MUL) || (state_q == scjf_pkg::ST_CMP) || (state_q == scjf_pkg::ST_FIN), "pending jet outside selection")
  `SCJF_ASSERT_IMP(a_empty_is_last, ov_q && !o_jv_q, o_last_q, "empty marker without last flag")

endmodule
